### design/vad_pkg.sv
`timescale 1ns / 1ps
// Shared constants, the arctangent step table and the sideband type for vector_angle_degrees.
package vad_pkg;

    localparam int ANGLE_ITERATIONS_DEFAULT = 20;
    localparam int CORDIC_MAX_ITER          = 32;

    localparam int COORD_W    = 32;
    localparam int DIFF_W     = 33;
    localparam int CORDIC_W   = 64;
    localparam int ANGLE_W    = 33;
    localparam int FIRST_Q_W  = 23;
    localparam int OUT_W      = 25;
    localparam int PRE_SHIFT  = 28;
    localparam int ROUND_DROP = 8;

    localparam logic [OUT_W-1:0] Q16_90  = 25'd5898240;
    localparam logic [OUT_W-1:0] Q16_180 = 25'd11796480;
    localparam logic [OUT_W-1:0] Q16_270 = 25'd17694720;
    localparam logic [OUT_W-1:0] Q16_360 = 25'd23592960;

    localparam logic signed [ANGLE_W-1:0] Q24_NINETY = 33'sd1509949440;
    localparam logic signed [ANGLE_W-1:0] ROUND_HALF = 33'sd128;

    // atan(2^-i) in units of 1e-10 degree.
    localparam logic [63:0] ATAN_DEG_E10 [CORDIC_MAX_ITER] = '{
        64'd450000000000, 64'd265650511771, 64'd140362434679, 64'd71250163489,
        64'd35763343750,  64'd17899106082,  64'd8951737102,   64'd4476141709,
        64'd2238105004,   64'd1119056771,   64'd559528919,    64'd279764526,
        64'd139882271,    64'd69941137,     64'd34970569,     64'd17485284,
        64'd8742642,      64'd4371321,      64'd2185661,      64'd1092830,
        64'd546415,       64'd273208,       64'd136604,       64'd68302,
        64'd34151,        64'd17075,        64'd8538,         64'd4269,
        64'd2134,         64'd1067,         64'd534,          64'd267
    };

    // Step angle in units of 2^-24 degree, rounded half up. Only called with constant indexes.
    function automatic logic signed [ANGLE_W-1:0] atan_q24(input int idx);
        logic [63:0] scaled;
        scaled = (ATAN_DEG_E10[idx] * 64'd16777216 + 64'd5000000000) / 64'd10000000000;
        return scaled[ANGLE_W-1:0];
    endfunction

    // Quadrant and axis information that travels beside the rotation datapath.
    typedef struct packed {
        logic             axis;
        logic [OUT_W-1:0] axis_angle;
        logic             dx_neg;
        logic             dy_neg;
    } side_t;

endpackage

### design/vector_angle_degrees.sv
`timescale 1ns / 1ps
// Top level: direction angle in degrees of the vector between two Q16.16 points.
//
//  Channel | Direction | Handshake          | Payload
//  s_      | in        | s_valid / s_ready  | s_start_x, s_start_y, s_end_x, s_end_y
//  m_      | out       | m_valid / m_ready  | m_angle_deg
//
// Registers in order: difference, magnitude setup, one stage per
// micro-rotation, clamp and round, quadrant fold; each has its own valid bit.
// One transaction is accepted every cycle while the output is not stalled.
// A stage stalls only when it is full and the stage after it is stalled, so
// bubbles are squeezed out. Reset is synchronous and clears the valid bits.
module vector_angle_degrees #(
    parameter int ANGLE_ITERATIONS = vad_pkg::ANGLE_ITERATIONS_DEFAULT
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                s_valid,
    output logic                                s_ready,
    input  logic signed [vad_pkg::COORD_W-1:0]  s_start_x,
    input  logic signed [vad_pkg::COORD_W-1:0]  s_start_y,
    input  logic signed [vad_pkg::COORD_W-1:0]  s_end_x,
    input  logic signed [vad_pkg::COORD_W-1:0]  s_end_y,
    output logic                                m_valid,
    input  logic                                m_ready,
    output logic [vad_pkg::OUT_W-1:0]           m_angle_deg
);

    localparam int NUM_ROT = (ANGLE_ITERATIONS > vad_pkg::CORDIC_MAX_ITER) ?
                             vad_pkg::CORDIC_MAX_ITER : ANGLE_ITERATIONS;

    // Difference stage.
    logic                               diff_valid_reg;
    logic                               diff_ready;
    logic                               setup_ready;
    logic signed [vad_pkg::DIFF_W-1:0]  dx_reg, dx_next;
    logic signed [vad_pkg::DIFF_W-1:0]  dy_reg, dy_next;

    assign dx_next = vad_pkg::DIFF_W'(s_end_x) - vad_pkg::DIFF_W'(s_start_x);
    assign dy_next = vad_pkg::DIFF_W'(s_end_y) - vad_pkg::DIFF_W'(s_start_y);
    assign diff_ready = !diff_valid_reg || setup_ready;
    assign s_ready = diff_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            diff_valid_reg <= 1'b0;
        end else if (diff_ready) begin
            diff_valid_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (diff_ready && s_valid) begin
            dx_reg <= dx_next;
            dy_reg <= dy_next;
        end
    end

    // Setup stage: magnitudes scaled into the rotation registers, quadrant noted.
    logic                                   setup_valid_reg;
    logic signed [vad_pkg::CORDIC_W-1:0]    setup_x_reg, setup_x_next;
    logic signed [vad_pkg::CORDIC_W-1:0]    setup_y_reg, setup_y_next;
    vad_pkg::side_t                         setup_side_reg, setup_side_next;
    logic                                   dx_zero, dy_zero;
    logic [vad_pkg::DIFF_W-1:0]             ax, ay;

    always_comb begin
        dx_zero = (dx_reg == '0);
        dy_zero = (dy_reg == '0);
        ax = dx_reg[vad_pkg::DIFF_W-1] ? $unsigned(-dx_reg) : $unsigned(dx_reg);
        ay = dy_reg[vad_pkg::DIFF_W-1] ? $unsigned(-dy_reg) : $unsigned(dy_reg);
        setup_x_next = {{(vad_pkg::CORDIC_W-vad_pkg::DIFF_W-vad_pkg::PRE_SHIFT){1'b0}},
                        ax, {vad_pkg::PRE_SHIFT{1'b0}}};
        setup_y_next = {{(vad_pkg::CORDIC_W-vad_pkg::DIFF_W-vad_pkg::PRE_SHIFT){1'b0}},
                        ay, {vad_pkg::PRE_SHIFT{1'b0}}};
        setup_side_next.dx_neg = dx_reg[vad_pkg::DIFF_W-1];
        setup_side_next.dy_neg = dy_reg[vad_pkg::DIFF_W-1];
        setup_side_next.axis   = dx_zero || dy_zero;
        // Coincident points and the positive x axis both give zero.
        if (dy_zero) begin
            setup_side_next.axis_angle = dx_reg[vad_pkg::DIFF_W-1] ? vad_pkg::Q16_180 : '0;
        end else begin
            setup_side_next.axis_angle = dy_reg[vad_pkg::DIFF_W-1] ? vad_pkg::Q16_270 :
                                                                      vad_pkg::Q16_90;
        end
    end

    logic                                   cv [NUM_ROT+1];
    logic                                   cr [NUM_ROT+1];
    logic signed [vad_pkg::CORDIC_W-1:0]    cx [NUM_ROT+1];
    logic signed [vad_pkg::CORDIC_W-1:0]    cy [NUM_ROT+1];
    logic signed [vad_pkg::ANGLE_W-1:0]     cz [NUM_ROT+1];
    vad_pkg::side_t                         cs [NUM_ROT+1];

    assign setup_ready = !setup_valid_reg || cr[0];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            setup_valid_reg <= 1'b0;
        end else if (setup_ready) begin
            setup_valid_reg <= diff_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (setup_ready && diff_valid_reg) begin
            setup_x_reg    <= setup_x_next;
            setup_y_reg    <= setup_y_next;
            setup_side_reg <= setup_side_next;
        end
    end

    assign cv[0] = setup_valid_reg;
    assign cx[0] = setup_x_reg;
    assign cy[0] = setup_y_reg;
    assign cz[0] = '0;
    assign cs[0] = setup_side_reg;

    // Micro-rotation stages.
    for (genvar k = 0; k < NUM_ROT; k++) begin : g_rot
        vad_cordic_stage #(
            .SHIFT     (k),
            .ATAN_STEP (vad_pkg::atan_q24(k))
        ) u_stage (
            .aclk      (aclk),
            .aresetn   (aresetn),
            .in_valid  (cv[k]),
            .in_ready  (cr[k]),
            .in_x      (cx[k]),
            .in_y      (cy[k]),
            .in_z      (cz[k]),
            .in_side   (cs[k]),
            .out_valid (cv[k+1]),
            .out_ready (cr[k+1]),
            .out_x     (cx[k+1]),
            .out_y     (cy[k+1]),
            .out_z     (cz[k+1]),
            .out_side  (cs[k+1])
        );
    end

    // Clamp to [0, 90] degrees and round half up to Q7.16.
    logic                                   rnd_valid_reg;
    logic                                   rnd_ready;
    logic                                   out_ready_int;
    logic [vad_pkg::FIRST_Q_W-1:0]          rnd_a_reg, rnd_a_next;
    vad_pkg::side_t                         rnd_side_reg;
    logic signed [vad_pkg::ANGLE_W-1:0]     z_clamp;
    logic signed [vad_pkg::ANGLE_W-1:0]     z_round;

    always_comb begin
        if (cz[NUM_ROT][vad_pkg::ANGLE_W-1]) begin
            z_clamp = '0;
        end else if (cz[NUM_ROT] > vad_pkg::Q24_NINETY) begin
            z_clamp = vad_pkg::Q24_NINETY;
        end else begin
            z_clamp = cz[NUM_ROT];
        end
        z_round    = z_clamp + vad_pkg::ROUND_HALF;
        rnd_a_next = z_round[vad_pkg::ROUND_DROP +: vad_pkg::FIRST_Q_W];
    end

    assign rnd_ready = !rnd_valid_reg || out_ready_int;
    assign cr[NUM_ROT] = rnd_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            rnd_valid_reg <= 1'b0;
        end else if (rnd_ready) begin
            rnd_valid_reg <= cv[NUM_ROT];
        end
    end

    always_ff @(posedge aclk) begin
        if (rnd_ready && cv[NUM_ROT]) begin
            rnd_a_reg    <= rnd_a_next;
            rnd_side_reg <= cs[NUM_ROT];
        end
    end

    // Quadrant fold and output register.
    logic                       res_valid_reg;
    logic [vad_pkg::OUT_W-1:0]  res_angle_reg, res_angle_next;
    logic [vad_pkg::OUT_W-1:0]  a_ext;
    logic [vad_pkg::OUT_W-1:0]  folded;

    always_comb begin
        a_ext = vad_pkg::OUT_W'(rnd_a_reg);
        if (rnd_side_reg.axis) begin
            folded = rnd_side_reg.axis_angle;
        end else if (!rnd_side_reg.dx_neg && !rnd_side_reg.dy_neg) begin
            folded = a_ext;
        end else if (rnd_side_reg.dx_neg && !rnd_side_reg.dy_neg) begin
            folded = vad_pkg::Q16_180 - a_ext;
        end else if (rnd_side_reg.dx_neg) begin
            folded = vad_pkg::Q16_180 + a_ext;
        end else begin
            folded = vad_pkg::Q16_360 - a_ext;
        end
        // A full turn wraps to zero.
        res_angle_next = (folded >= vad_pkg::Q16_360) ? '0 : folded;
    end

    assign out_ready_int = !res_valid_reg || m_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            res_valid_reg <= 1'b0;
        end else if (out_ready_int) begin
            res_valid_reg <= rnd_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (out_ready_int && rnd_valid_reg) begin
            res_angle_reg <= res_angle_next;
        end
    end

    assign m_valid     = res_valid_reg;
    assign m_angle_deg = res_angle_reg;

    // The result always lies below a full turn.
    a_angle_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_angle_deg < vad_pkg::Q16_360))
        else $error("angle result at or above 360 degrees");

    // With the sink ready, every stage can advance, so the input must be open.
    a_ready_chain: assert property (@(posedge aclk) disable iff (!aresetn)
        m_ready |-> s_ready)
        else $error("input stalled although the sink is ready");

    // Reset empties the pipeline.
    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> (!m_valid && !rnd_valid_reg && !diff_valid_reg))
        else $error("valid bit survived reset");

    // A stage never overwrites a held result while the output is stalled.
    a_hold_result: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_ready) |=> (m_valid && $stable(res_angle_reg)))
        else $error("held result changed during a stall");

endmodule

### design/vad_cordic_stage.sv
`timescale 1ns / 1ps
// One registered vectoring micro-rotation of the arctangent pipeline.
module vad_cordic_stage #(
    parameter int                                   SHIFT     = 0,
    parameter logic signed [vad_pkg::ANGLE_W-1:0]   ATAN_STEP = '0
) (
    input  logic                                    aclk,
    input  logic                                    aresetn,
    input  logic                                    in_valid,
    output logic                                    in_ready,
    input  logic signed [vad_pkg::CORDIC_W-1:0]     in_x,
    input  logic signed [vad_pkg::CORDIC_W-1:0]     in_y,
    input  logic signed [vad_pkg::ANGLE_W-1:0]      in_z,
    input  vad_pkg::side_t                          in_side,
    output logic                                    out_valid,
    input  logic                                    out_ready,
    output logic signed [vad_pkg::CORDIC_W-1:0]     out_x,
    output logic signed [vad_pkg::CORDIC_W-1:0]     out_y,
    output logic signed [vad_pkg::ANGLE_W-1:0]      out_z,
    output vad_pkg::side_t                          out_side
);

    logic                                   valid_reg;
    logic signed [vad_pkg::CORDIC_W-1:0]    x_reg, x_next;
    logic signed [vad_pkg::CORDIC_W-1:0]    y_reg, y_next;
    logic signed [vad_pkg::ANGLE_W-1:0]     z_reg, z_next;
    vad_pkg::side_t                         side_reg;

    logic                                   y_neg;
    logic [vad_pkg::CORDIC_W-1:0]           y_mag;
    logic [vad_pkg::CORDIC_W-1:0]           ys_mag;
    logic signed [vad_pkg::CORDIC_W-1:0]    xs;
    logic signed [vad_pkg::CORDIC_W-1:0]    ys;

    // Shifts truncate the magnitude toward zero; x never goes negative.
    always_comb begin
        y_neg  = in_y[vad_pkg::CORDIC_W-1];
        y_mag  = y_neg ? $unsigned(-in_y) : $unsigned(in_y);
        ys_mag = y_mag >> SHIFT;
        ys     = y_neg ? -$signed(ys_mag) : $signed(ys_mag);
        xs     = in_x >>> SHIFT;
        if (!y_neg) begin
            x_next = in_x + ys;
            y_next = in_y - xs;
            z_next = in_z + ATAN_STEP;
        end else begin
            x_next = in_x - ys;
            y_next = in_y + xs;
            z_next = in_z - ATAN_STEP;
        end
    end

    assign in_ready = !valid_reg || out_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (in_ready) begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_ready && in_valid) begin
            x_reg    <= x_next;
            y_reg    <= y_next;
            z_reg    <= z_next;
            side_reg <= in_side;
        end
    end

    assign out_valid = valid_reg;
    assign out_x     = x_reg;
    assign out_y     = y_reg;
    assign out_z     = z_reg;
    assign out_side  = side_reg;

endmodule

### sim/testbench.sv
`timescale 1ns / 1ps
// Self-checking testbench for vector_angle_degrees: random and corner-case point pairs against a CORDIC predictor.
module testbench;

    localparam int ITERS          = vad_pkg::ANGLE_ITERATIONS_DEFAULT;
    localparam int LATENCY        = ITERS + 4;
    localparam int RANDOM_PAIRS   = 800;
    localparam int TIMEOUT_CYCLES = 200000;

    localparam logic signed [31:0] C_MIN = 32'sh8000_0000;
    localparam logic signed [31:0] C_MAX = 32'sh7FFF_FFFF;
    localparam logic signed [31:0] C_ONE = 32'sh0001_0000;

    localparam longint DEG_90  = 64'd90 << 16;
    localparam longint DEG_180 = 64'd180 << 16;
    localparam longint DEG_270 = 64'd270 << 16;
    localparam longint DEG_360 = 64'd360 << 16;
    localparam longint Q24_90  = 64'd90 << 24;

    typedef struct packed {
        logic signed [vad_pkg::COORD_W-1:0] start_x;
        logic signed [vad_pkg::COORD_W-1:0] start_y;
        logic signed [vad_pkg::COORD_W-1:0] end_x;
        logic signed [vad_pkg::COORD_W-1:0] end_y;
    } point_pair_t;

    typedef enum logic [1:0] {RX_ALWAYS, RX_COIN, RX_RARE_STALL, RX_PERIODIC} rx_mode_t;

    logic                              aclk;
    logic                              aresetn = 1'b0;
    logic                              s_valid = 1'b0;
    logic                              s_ready;
    logic signed [vad_pkg::COORD_W-1:0] s_start_x;
    logic signed [vad_pkg::COORD_W-1:0] s_start_y;
    logic signed [vad_pkg::COORD_W-1:0] s_end_x;
    logic signed [vad_pkg::COORD_W-1:0] s_end_y;
    logic                              m_valid;
    logic                              m_ready = 1'b0;
    logic [vad_pkg::OUT_W-1:0]         m_angle_deg;

    point_pair_t offered_pair = '0;
    point_pair_t pending_pairs [$];
    logic [vad_pkg::OUT_W-1:0] expected_angles [$];
    logic [vad_pkg::OUT_W-1:0] wanted_angle;

    int       pair_total     = 0;
    int       accepted_count = 0;
    int       result_count   = 0;
    int       error_count    = 0;
    int       cycle_count    = 0;
    int       burst_left     = 0;
    int       gap_left       = 0;
    int       mode_left      = 0;
    int       hold_left      = 0;
    logic     hold_done      = 1'b0;
    logic [7:0] rx_phase     = '0;
    rx_mode_t ready_mode     = RX_ALWAYS;

    // atan(2^-i) in units of 1e-10 degree.
    longint unsigned atan_e10_deg [32] = '{
        64'd450000000000, 64'd265650511771, 64'd140362434679, 64'd71250163489,
        64'd35763343750,  64'd17899106082,  64'd8951737102,   64'd4476141709,
        64'd2238105004,   64'd1119056771,   64'd559528919,    64'd279764526,
        64'd139882271,    64'd69941137,     64'd34970569,     64'd17485284,
        64'd8742642,      64'd4371321,      64'd2185661,      64'd1092830,
        64'd546415,       64'd273208,       64'd136604,       64'd68302,
        64'd34151,        64'd17075,        64'd8538,         64'd4269,
        64'd2134,         64'd1067,         64'd534,          64'd267
    };

    assign s_start_x = offered_pair.start_x;
    assign s_start_y = offered_pair.start_y;
    assign s_end_x   = offered_pair.end_x;
    assign s_end_y   = offered_pair.end_y;

    vector_angle_degrees dut (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_start_x   (s_start_x),
        .s_start_y   (s_start_y),
        .s_end_x     (s_end_x),
        .s_end_y     (s_end_y),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_angle_deg (m_angle_deg)
    );

    // Direction of (end - start) in Q9.16 degrees, folded from a first-quadrant CORDIC angle.
    function automatic logic [vad_pkg::OUT_W-1:0] direction_angle(input point_pair_t p);
        longint dx, dy, ax, ay, x, y, z, xs, ys, step;
        longint unsigned fq, r;
        dx = $signed(p.end_x);
        dx = dx - $signed(p.start_x);
        dy = $signed(p.end_y);
        dy = dy - $signed(p.start_y);
        ax = (dx < 0) ? -dx : dx;
        ay = (dy < 0) ? -dy : dy;
        if (dx == 0 && dy == 0) begin
            r = 0;
        end else if (dy == 0) begin
            r = (dx > 0) ? 0 : DEG_180;
        end else if (dx == 0) begin
            r = (dy > 0) ? DEG_90 : DEG_270;
        end else begin
            x = ax <<< vad_pkg::PRE_SHIFT;
            y = ay <<< vad_pkg::PRE_SHIFT;
            z = 0;
            for (int i = 0; i < ITERS && i < 32; i++) begin
                // Right shifts truncate the magnitude, so negative values round toward zero.
                xs = (x >= 0) ? (x >>> i) : -((-x) >>> i);
                ys = (y >= 0) ? (y >>> i) : -((-y) >>> i);
                step = longint'((atan_e10_deg[i] * 64'd16777216 + 64'd5000000000)
                                / 64'd10000000000);
                if (y >= 0) begin
                    x = x + ys;
                    y = y - xs;
                    z = z + step;
                end else begin
                    x = x - ys;
                    y = y + xs;
                    z = z - step;
                end
            end
            if (z < 0) z = 0;
            if (z > Q24_90) z = Q24_90;
            fq = (longint'(z) + 128) >> 8;
            if (fq > DEG_90) fq = DEG_90;
            if (dx > 0 && dy > 0)
                r = fq;
            else if (dx < 0 && dy > 0)
                r = DEG_180 - fq;
            else if (dx < 0)
                r = DEG_180 + fq;
            else
                r = DEG_360 - fq;
        end
        if (r >= DEG_360) r = 0;
        return r[vad_pkg::OUT_W-1:0];
    endfunction

    task automatic report_mismatch(input string what, input logic [vad_pkg::OUT_W-1:0] got,
                                   input logic [vad_pkg::OUT_W-1:0] want);
        $display("%0t: result %0d: %s: angle_deg got %0d expected %0d",
                 $time, result_count, what, got, want);
        error_count++;
    endtask

    task automatic add_pair(input logic signed [31:0] sx, input logic signed [31:0] sy,
                            input logic signed [31:0] ex, input logic signed [31:0] ey);
        point_pair_t p;
        p.start_x = sx;
        p.start_y = sy;
        p.end_x   = ex;
        p.end_y   = ey;
        pending_pairs.push_back(p);
    endtask

    function automatic logic signed [31:0] corner_value();
        case ($urandom_range(0, 4))
            0:       return C_MIN;
            1:       return C_MAX;
            2:       return 32'sd0;
            3:       return -32'sd1;
            default: return 32'sd1;
        endcase
    endfunction

    function automatic point_pair_t random_pair();
        point_pair_t p;
        int          delta;
        p.start_x = $urandom;
        p.start_y = $urandom;
        p.end_x   = $urandom;
        p.end_y   = $urandom;
        case ($urandom_range(0, 9))
            4, 5: begin
                // Short vectors, at most 1/16 unit of Q16.16 along each axis.
                delta = $urandom_range(0, 8191);
                p.end_x = p.start_x + delta - 4096;
                delta = $urandom_range(0, 8191);
                p.end_y = p.start_y + delta - 4096;
            end
            6: begin
                if ($urandom_range(0, 1) == 0)
                    p.end_y = p.start_y;
                else
                    p.end_x = p.start_x;
            end
            7: begin
                p.end_x = p.start_x;
                p.end_y = p.start_y;
            end
            8: begin
                // Nearly horizontal either way; along +x, rounding decides between 0 and the wrap.
                delta = $urandom_range(0, 6);
                p.end_y = p.start_y + delta - 3;
                if ($urandom_range(0, 1) == 0) begin
                    p.start_x = C_MIN + $urandom_range(0, 255);
                    p.end_x   = C_MAX - $urandom_range(0, 255);
                end else begin
                    p.start_x = C_MAX - $urandom_range(0, 255);
                    p.end_x   = C_MIN + $urandom_range(0, 255);
                end
            end
            9: begin
                p.start_x = corner_value();
                p.start_y = corner_value();
                p.end_x   = corner_value();
                p.end_y   = corner_value();
            end
            default: ;
        endcase
        return p;
    endfunction

    initial begin
        aclk = 1'b0;
        forever #4 aclk = ~aclk;
    end

    // Sender: bursts of random length separated by random gaps, which may be empty.
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else begin
            if (s_valid && s_ready) begin
                expected_angles.push_back(direction_angle(offered_pair));
                accepted_count <= accepted_count + 1;
            end
            if (!s_valid || s_ready) begin
                if (gap_left != 0) begin
                    gap_left <= gap_left - 1;
                    s_valid  <= 1'b0;
                end else if (pending_pairs.size() != 0) begin
                    offered_pair <= pending_pairs.pop_front();
                    s_valid      <= 1'b1;
                    if (burst_left <= 1) begin
                        burst_left <= $urandom_range(1, 32);
                        gap_left   <= ($urandom_range(0, 1) == 0) ? 0 : $urandom_range(1, 8);
                    end else begin
                        burst_left <= burst_left - 1;
                    end
                end else begin
                    s_valid <= 1'b0;
                end
            end
        end
    end

    // One long hold-off on the result side once traffic is flowing, so the pipeline backs up.
    always @(posedge aclk) begin
        if (!aresetn) begin
            hold_left <= 0;
        end else if (hold_left != 0) begin
            hold_left <= hold_left - 1;
        end else if (!hold_done && accepted_count >= 200) begin
            hold_left <= 400;
            hold_done <= 1'b1;
        end
    end

    // Receiver: switches between stall patterns every so often.
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else begin
            rx_phase <= rx_phase + 1;
            if (mode_left == 0) begin
                ready_mode <= rx_mode_t'($urandom_range(0, 3));
                mode_left  <= $urandom_range(20, 150);
            end else begin
                mode_left <= mode_left - 1;
            end
            if (hold_left != 0) begin
                m_ready <= 1'b0;
            end else begin
                case (ready_mode)
                    RX_ALWAYS:     m_ready <= 1'b1;
                    RX_COIN:       m_ready <= 1'($urandom_range(0, 1));
                    RX_RARE_STALL: m_ready <= ($urandom_range(0, 7) != 0);
                    default:       m_ready <= (rx_phase[1:0] != 2'd0);
                endcase
            end
        end
    end

    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            if (expected_angles.size() == 0) begin
                report_mismatch("unexpected transaction", m_angle_deg, '0);
            end else begin
                wanted_angle = expected_angles.pop_front();
                if (m_angle_deg !== wanted_angle)
                    report_mismatch("wrong angle", m_angle_deg, wanted_angle);
            end
            result_count <= result_count + 1;
        end
    end

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == TIMEOUT_CYCLES) begin
            $display("%0t: timed out with %0d results outstanding", $time,
                     expected_angles.size());
            $display("vector_angle_degrees regression: fail");
            $finish;
        end
    end

    initial begin
        // Coincident points.
        add_pair(32'sd0, 32'sd0, 32'sd0, 32'sd0);
        add_pair(C_MIN, C_MAX, C_MIN, C_MAX);
        add_pair(-32'sd1, -32'sd1, -32'sd1, -32'sd1);
        // Exact axis directions, short and at full reach.
        add_pair(32'sd0, 32'sd0, C_ONE, 32'sd0);
        add_pair(32'sd0, 32'sd0, 32'sd0, C_ONE);
        add_pair(32'sd0, 32'sd0, -C_ONE, 32'sd0);
        add_pair(32'sd0, 32'sd0, 32'sd0, -C_ONE);
        add_pair(C_MIN, 32'sd0, C_MAX, 32'sd0);
        add_pair(C_MAX, C_MIN, C_MIN, C_MIN);
        add_pair(C_MAX, C_MIN, C_MAX, C_MAX);
        add_pair(32'sd0, C_MAX, 32'sd0, C_MIN);
        // Diagonals in each quadrant.
        add_pair(32'sd0, 32'sd0, C_ONE, C_ONE);
        add_pair(32'sd0, 32'sd0, -C_ONE, C_ONE);
        add_pair(32'sd0, 32'sd0, -C_ONE, -C_ONE);
        add_pair(32'sd0, 32'sd0, C_ONE, -C_ONE);
        add_pair(C_MIN, C_MIN, C_MAX, C_MAX);
        add_pair(C_MAX, C_MAX, C_MIN, C_MIN);
        // Tiny slopes off the x axis both ways; the one just below a full turn rounds to 360 and wraps to zero.
        add_pair(C_MIN, 32'sd1, C_MAX, 32'sd0);
        add_pair(C_MIN, 32'sd0, C_MAX, 32'sd1);
        add_pair(C_MAX, 32'sd0, C_MIN, 32'sd1);
        add_pair(C_MAX, 32'sd1, C_MIN, 32'sd0);
        // Nearly vertical, where the first-quadrant angle saturates at 90; then a diagonal and a shallow slope.
        add_pair(32'sd0, C_MIN, 32'sd1, C_MAX);
        add_pair(32'sd0, C_MAX, -32'sd1, C_MIN);
        add_pair(32'sh5555_5555, 32'shAAAA_AAAA, 32'shAAAA_AAAA, 32'sh5555_5555);
        add_pair(32'sd0, 32'sd0, 32'sd3, -32'sd1);
        repeat (RANDOM_PAIRS) pending_pairs.push_back(random_pair());
        pair_total = pending_pairs.size();

        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;

        while (!(accepted_count == pair_total && expected_angles.size() == 0))
            @(posedge aclk);
        repeat (LATENCY + 8) @(posedge aclk);

        if (error_count == 0)
            $display("vector_angle_degrees regression: pass");
        else
            $display("vector_angle_degrees regression: fail");
        $finish;
    end

endmodule

### sim.f
design/vad_pkg.sv
design/vad_cordic_stage.sv
design/vector_angle_degrees.sv
sim/testbench.sv
